// ===== rtl/wbg_pkg.sv =====
// ----------------------------------------------------------------------------
// wbg_pkg: shared types and constants for the waypoint bearing guidance block
// Holds field widths, register indexes, reset values, the sequencer state
// type, unit status structs and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package wbg_pkg;

  // Number of waypoints in the route; the last one ends the mission.
  localparam int WAYPOINT_COUNT = 3;

  // Field widths.
  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int RADIUS_W  = 15;
  localparam int THRUST_W  = 8;
  localparam int HEADING_W = 15;
  localparam int INDEX_W   = 2;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // CORDIC datapath: coordinates carry 20 fraction bits, angles are 2^-22 degree.
  localparam int FRAC_W       = 20;
  localparam int XY_W         = 40;
  localparam int Z_W          = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam logic signed [Z_W-1:0] ANGLE_90 = 32'sd377487360;
  localparam logic signed [15:0] HEADING_MAX = 16'sd11520;

  // Product and distance widths.
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DIST_W = 33;

  // Register reset values.
  localparam logic [COORD_W-1:0]  WP0_X_RST   = 16'd100;
  localparam logic [COORD_W-1:0]  WP0_Y_RST   = 16'd300;
  localparam logic [COORD_W-1:0]  WP1_X_RST   = 16'd150;
  localparam logic [COORD_W-1:0]  WP1_Y_RST   = 16'd600;
  localparam logic [COORD_W-1:0]  WP2_X_RST   = 16'd100;
  localparam logic [COORD_W-1:0]  WP2_Y_RST   = 16'd900;
  localparam logic [RADIUS_W-1:0] RADIUS_RST  = 15'd30;
  localparam logic [THRUST_W-1:0] THRUST_RST  = 8'd10;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WP0_X   = 3'd0,
    REG_WP0_Y   = 3'd1,
    REG_WP1_X   = 3'd2,
    REG_WP1_Y   = 3'd3,
    REG_WP2_X   = 3'd4,
    REG_WP2_Y   = 3'd5,
    REG_RADIUS  = 3'd6,
    REG_THRUST  = 3'd7
  } wbg_reg_t;

  // Top level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_CORDIC,
    ST_OUT
  } wbg_state_t;

  // Status of the distance unit.
  typedef struct packed {
    logic done;
    logic captured;
  } wbg_dist_stat_t;

  // Status of the bearing unit.
  typedef struct packed {
    logic                        done;
    logic signed [HEADING_W-1:0] heading;
  } wbg_cordic_stat_t;

  // Arctangent of 2^-i in units of 2^-22 degree.
  function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] t;
    begin
      case (i)
        5'd0:    t = 32'sd188743680;
        5'd1:    t = 32'sd111421900;
        5'd2:    t = 32'sd58872272;
        5'd3:    t = 32'sd29884485;
        5'd4:    t = 32'sd15000234;
        5'd5:    t = 32'sd7507429;
        5'd6:    t = 32'sd3754631;
        5'd7:    t = 32'sd1877430;
        5'd8:    t = 32'sd938729;
        5'd9:    t = 32'sd469366;
        5'd10:   t = 32'sd234683;
        5'd11:   t = 32'sd117342;
        5'd12:   t = 32'sd58671;
        5'd13:   t = 32'sd29335;
        5'd14:   t = 32'sd14668;
        5'd15:   t = 32'sd7334;
        5'd16:   t = 32'sd3667;
        5'd17:   t = 32'sd1833;
        5'd18:   t = 32'sd917;
        5'd19:   t = 32'sd458;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

// ===== rtl/wbg_dist.sv =====
// ----------------------------------------------------------------------------
// wbg_dist: capture test with one shared multiplier
// Squares dx, dy and the radius in turn on a single 17x17 multiplier,
// sums the squares and flags whether the distance is inside the radius.
// ----------------------------------------------------------------------------
module wbg_dist
  import wbg_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [DIFF_W-1:0]   dx,
  input  logic signed [DIFF_W-1:0]   dy,
  input  logic        [RADIUS_W-1:0] radius,
  output wbg_dist_stat_t             stat
);

  logic                     busy;
  logic [1:0]               cnt;
  logic signed [DIFF_W-1:0] op;
  logic signed [PROD_W-1:0] prod;
  logic [DIST_W-1:0]        acc;
  logic                     done;
  logic                     captured;

  // Operand for the shared multiplier follows the step count.
  always_comb begin
    case (cnt)
      2'd0:    op = dx;
      2'd1:    op = dy;
      2'd2:    op = $signed({{(DIFF_W-RADIUS_W){1'b0}}, radius});
      default: op = '0;
    endcase
  end

  // Control: four steps per test, done pulses for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: product register, then accumulate, then compare.
  always_ff @(posedge clk) begin
    if (busy) begin
      prod <= op * op;
      case (cnt)
        2'd1:    acc <= prod[DIST_W-1:0];
        2'd2:    acc <= acc + prod[DIST_W-1:0];
        2'd3:    captured <= acc < prod[DIST_W-1:0];
        default: acc <= acc;
      endcase
    end
  end

  assign stat.done     = done;
  assign stat.captured = captured;

endmodule

// ===== rtl/wbg_cordic.sv =====
// ----------------------------------------------------------------------------
// wbg_cordic: iterative CORDIC bearing unit
// Takes a vector, rotates it into the right half plane and runs twenty
// vectoring steps on one shared add and shift stage, one step per cycle.
// The angle is rounded to 1/64 degree and limited to plus or minus 180.
// ----------------------------------------------------------------------------
module wbg_cordic
  import wbg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] bx,
  input  logic signed [DIFF_W-1:0] by,
  output wbg_cordic_stat_t         stat
);

  logic                        busy;
  logic                        fin;
  logic [STEP_W-1:0]           cnt;
  logic signed [XY_W-1:0]      x;
  logic signed [XY_W-1:0]      y;
  logic signed [Z_W-1:0]       z;
  logic signed [XY_W-1:0]      x_init;
  logic signed [XY_W-1:0]      y_init;
  logic signed [Z_W-1:0]       z_init;
  logic signed [DIFF_W:0]      bx_e;
  logic signed [DIFF_W:0]      by_e;
  logic signed [XY_W-1:0]      sx;
  logic signed [XY_W-1:0]      sy;
  logic signed [Z_W-1:0]       ang;
  logic signed [Z_W-1:0]       z_rnd;
  logic signed [15:0]          h;
  logic signed [HEADING_W-1:0] h_lim;
  logic                        done;
  logic signed [HEADING_W-1:0] heading;

  // Scale an 18-bit value into the fixed-point coordinate format.
  function automatic logic signed [XY_W-1:0] scale(input logic signed [DIFF_W:0] v);
    return {{(XY_W-DIFF_W-1-FRAC_W){v[DIFF_W]}}, v, {FRAC_W{1'b0}}};
  endfunction

  // Pre-rotation into the right half plane.
  always_comb begin
    bx_e = {bx[DIFF_W-1], bx};
    by_e = {by[DIFF_W-1], by};
    if (bx_e < 0) begin
      if (by_e >= 0) begin
        x_init = scale(by_e);
        y_init = scale(-bx_e);
        z_init = ANGLE_90;
      end else begin
        x_init = scale(-by_e);
        y_init = scale(bx_e);
        z_init = -ANGLE_90;
      end
    end else begin
      x_init = scale(bx_e);
      y_init = scale(by_e);
      z_init = '0;
    end
  end

  // Shared step: floor shifts of the old x and y, table angle.
  assign sx  = x >>> cnt;
  assign sy  = y >>> cnt;
  assign ang = atan_entry(cnt);

  // Round to 1/64 degree and limit.
  always_comb begin
    z_rnd = z + 32'sd32768;
    h     = z_rnd[Z_W-1:16];
    if (h > HEADING_MAX) begin
      h_lim = HEADING_MAX[HEADING_W-1:0];
    end else if (h < -HEADING_MAX) begin
      h_lim = HEADING_W'(-HEADING_MAX);
    end else begin
      h_lim = h[HEADING_W-1:0];
    end
  end

  // Control: load, twenty steps, a finishing step; a zero vector skips the steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (bx == '0 && by == '0) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      x       <= x_init;
      y       <= y_init;
      z       <= z_init;
      heading <= '0;
    end else if (busy) begin
      if (!y[XY_W-1]) begin
        x <= x + sy;
        y <= y - sx;
        z <= z + ang;
      end else begin
        x <= x - sy;
        y <= y + sx;
        z <= z - ang;
      end
    end else if (fin) begin
      heading <= h_lim;
    end
  end

  assign stat.done    = done;
  assign stat.heading = heading;

endmodule

// ===== rtl/waypoint_bearing_guidance.sv =====
// ----------------------------------------------------------------------------
// waypoint_bearing_guidance: waypoint following guidance top level
// Position ticks enter on the s_axis channel, guidance results leave on the
// m_axis channel, waypoints and limits are written on the cfg channel.
//
// Each tick carries pos_x, pos_y and stop_request. While the mission runs,
// a tick is checked against the capture radius of the current waypoint; on
// capture the block moves to the next waypoint with zero commands, or at the
// last waypoint reports mission_done and power_down and stops. Otherwise it
// returns the bearing to the waypoint with cruise thrust. A tick with
// stop_request set, and every tick after the mission has stopped, is taken
// and produces no result.
//
// Sequence: a tick first runs the capture test on the shared multiplier;
// when it is not captured, the bearing then runs on the iterative CORDIC
// stage, and the result goes to the result register. s_axis_tready is
// high only while no tick is in work.
// A result waits in the output register while m_axis_tready is low; the
// next tick may be taken meanwhile, and its result waits until the held one
// has gone. Reset restores the default route and restarts the mission.
// ----------------------------------------------------------------------------
module waypoint_bearing_guidance
  import wbg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Position ticks. tdata, lowest bit up: pos_x[15:0], pos_y[31:16],
  // stop_request[32], zero fill [39:33].
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,
  // Results. tdata, lowest bit up: heading_cmd[14:0], heading_closed[15],
  // thrust_cmd[23:16], mission_done[24], power_down[25],
  // waypoint_index[27:26], zero fill [31:28].
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,
  // Register writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(WAYPOINT_COUNT - 1);

  wbg_state_t state;
  wbg_state_t state_next;

  logic [COORD_W-1:0]  wp0_x, wp0_y, wp1_x, wp1_y, wp2_x, wp2_y;
  logic [RADIUS_W-1:0] radius;
  logic [THRUST_W-1:0] cruise;
  logic [INDEX_W-1:0]  target_index;
  logic                running;

  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dx_next;
  logic signed [DIFF_W-1:0] dy_next;
  logic signed [DIFF_W-1:0] bx;
  logic signed [DIFF_W-1:0] by;
  logic [COORD_W-1:0]       wx;
  logic [COORD_W-1:0]       wy;

  logic                        in_xfer;
  logic                        stop_req;
  logic                        dist_start;
  logic                        cordic_start;
  logic                        load_out;
  wbg_dist_stat_t              dist_stat;
  wbg_cordic_stat_t            cordic_stat;

  logic [HEADING_W-1:0] res_heading;
  logic                 res_closed;
  logic [THRUST_W-1:0]  res_thrust;
  logic                 res_done;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp0_x  <= WP0_X_RST;
      wp0_y  <= WP0_Y_RST;
      wp1_x  <= WP1_X_RST;
      wp1_y  <= WP1_Y_RST;
      wp2_x  <= WP2_X_RST;
      wp2_y  <= WP2_Y_RST;
      radius <= RADIUS_RST;
      cruise <= THRUST_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WP0_X:  wp0_x  <= cfg_data;
        REG_WP0_Y:  wp0_y  <= cfg_data;
        REG_WP1_X:  wp1_x  <= cfg_data;
        REG_WP1_Y:  wp1_y  <= cfg_data;
        REG_WP2_X:  wp2_x  <= cfg_data;
        REG_WP2_Y:  wp2_y  <= cfg_data;
        REG_RADIUS: radius <= cfg_data[RADIUS_W-1:0];
        REG_THRUST: cruise <= cfg_data[THRUST_W-1:0];
        default:    radius <= radius;
      endcase
    end
  end

  // Current waypoint; indexes past the route select the last entry.
  always_comb begin
    case (target_index)
      2'd0:    begin wx = wp0_x; wy = wp0_y; end
      2'd1:    begin wx = wp1_x; wy = wp1_y; end
      default: begin wx = wp2_x; wy = wp2_y; end
    endcase
  end

  // Offsets from the waypoint to the vehicle.
  assign dx_next = $signed({s_axis_tdata[COORD_W-1], s_axis_tdata[COORD_W-1:0]})
                 - $signed({wx[COORD_W-1], wx});
  assign dy_next = $signed({s_axis_tdata[2*COORD_W-1], s_axis_tdata[2*COORD_W-1:COORD_W]})
                 - $signed({wy[COORD_W-1], wy});
  assign stop_req = s_axis_tdata[2*COORD_W];
  assign in_xfer  = s_axis_tvalid && s_axis_tready;

  // The bearing looks from the vehicle toward the waypoint.
  assign bx = -dx;
  assign by = -dy;

  wbg_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .start  (dist_start),
    .dx     (dx),
    .dy     (dy),
    .radius (radius),
    .stat   (dist_stat)
  );

  wbg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .bx    (bx),
    .by    (by),
    .stat  (cordic_stat)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && running && !stop_req) state_next = ST_DIST;
      end
      ST_DIST: begin
        if (dist_stat.done) begin
          state_next = dist_stat.captured ? ST_OUT : ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cordic_stat.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    dist_start    = 1'b0;
    cordic_start  = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        dist_start    = in_xfer && running && !stop_req;
      end
      ST_DIST:   cordic_start = dist_stat.done && !dist_stat.captured;
      ST_CORDIC: cordic_start = 1'b0;
      ST_OUT:    load_out     = !m_axis_tvalid || m_axis_tready;
      default:   load_out     = 1'b0;
    endcase
  end

  // Control state: sequencer, mission progress, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      target_index  <= '0;
      running       <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_xfer && stop_req) running <= 1'b0;
      if (state == ST_DIST && dist_stat.done && dist_stat.captured) begin
        if (target_index >= LAST_INDEX) begin
          running <= 1'b0;
        end else begin
          target_index <= target_index + 2'd1;
        end
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dx <= dx_next;
      dy <= dy_next;
    end
    if (state == ST_DIST && dist_stat.done) begin
      res_heading <= '0;
      res_closed  <= 1'b0;
      res_thrust  <= '0;
      res_done    <= target_index >= LAST_INDEX;
    end else if (state == ST_CORDIC && cordic_stat.done) begin
      res_heading <= cordic_stat.heading;
      res_closed  <= 1'b1;
      res_thrust  <= cruise;
      res_done    <= 1'b0;
    end
    if (load_out) begin
      m_axis_tdata <= {4'b0, target_index, res_done, res_done, res_thrust,
                       res_closed, res_heading};
    end
  end

`ifndef ASSERT_OFF
  // The target index never runs past the last waypoint.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    target_index <= LAST_INDEX)
    else $error("target index beyond last waypoint");
`endif
`ifndef ASSERT_OFF
  // A stop request ends the mission.
  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && stop_req) |=> !running)
    else $error("stop request did not halt the mission");
`endif
`ifndef ASSERT_OFF
  // A held result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> state == ST_OUT)
    else $error("result left the output stage while the receiver stalled");
`endif
`ifndef ASSERT_OFF
  // The bearing unit only runs after a capture test that missed.
  a_cordic_after_miss: assert property (@(posedge clk) disable iff (rst)
    cordic_start |-> (dist_stat.done && !dist_stat.captured))
    else $error("bearing started without a missed capture test");
`endif
`ifndef ASSERT_OFF
  // A completed mission reports done only once it has stopped running.
  a_done_stops: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_done) |-> !running)
    else $error("mission done reported while still running");
`endif

endmodule

// ===== test/tb_waypoint_bearing_guidance.sv =====
// ----------------------------------------------------------------------------
// tb_waypoint_bearing_guidance: self-checking bench for the guidance block
// Position ticks are streamed in under changing routes, capture radii and
// thrust levels while both stream sides idle at random. A predictor tracks
// the route index and mission state and computes each expected result,
// including the CORDIC bearing. Results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_waypoint_bearing_guidance;
  import wbg_pkg::*;

  // Position tick as packed on s_axis_tdata, lowest bit up.
  typedef struct packed {
    logic [6:0]         fill;
    logic               stop_request;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
  } tick_t;

  // Guidance result as packed on m_axis_tdata, lowest bit up.
  typedef struct packed {
    logic [3:0]         fill;
    logic [1:0]         waypoint_index;
    logic               power_down;
    logic               mission_done;
    logic [7:0]         thrust_cmd;
    logic               heading_closed;
    logic signed [14:0] heading_cmd;
  } guidance_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Predictor copy of the registers and the mission state.
  logic signed [15:0] wp_x [3];
  logic signed [15:0] wp_y [3];
  logic [14:0]        capture_r;
  logic [7:0]         cruise_level;
  logic [1:0]         route_index;
  logic               mission_active;

  // Stimulus plan: route state as the generated ticks will leave it.
  logic [1:0] plan_index = '0;
  logic       plan_running = 1'b1;

  tick_t     tick_backlog [$];
  guidance_t expected_guidance [$];
  int        ticks_queued = 0;
  int        ticks_taken = 0;
  int        mismatch_count = 0;
  int        source_idle_pct = 0;
  int        sink_stall_pct = 0;
  logic      tick_taken = 1'b0;
  logic      sink_blocked = 1'b0;
  event      receiver_hold;

  waypoint_bearing_guidance uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Arctangent of 2^-i in units of 2^-22 degree.
  function automatic longint arctan_step(int i);
    case (i)
      0:       return 188743680;
      1:       return 111421900;
      2:       return 58872272;
      3:       return 29884485;
      4:       return 15000234;
      5:       return 7507429;
      6:       return 3754631;
      7:       return 1877430;
      8:       return 938729;
      9:       return 469366;
      10:      return 234683;
      11:      return 117342;
      12:      return 58671;
      13:      return 29335;
      14:      return 14668;
      15:      return 7334;
      16:      return 3667;
      17:      return 1833;
      18:      return 917;
      default: return 458;
    endcase
  endfunction

  // Bearing of the vector (bx, by) in 1/64 degree by 20 vectoring steps.
  function automatic logic signed [14:0] bearing_to(longint bx, longint by);
    longint x, y, z, t;
    int     i;
    if (bx == 0 && by == 0) return '0;
    if (bx < 0) begin
      if (by >= 0) begin
        x = by;
        y = -bx;
        z = longint'(ANGLE_90);
      end else begin
        x = -by;
        y = bx;
        z = -longint'(ANGLE_90);
      end
    end else begin
      x = bx;
      y = by;
      z = 0;
    end
    x = x * 64'sd1048576;
    y = y * 64'sd1048576;
    for (i = 0; i < 20; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + arctan_step(i);
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - arctan_step(i);
      end
    end
    z = (z + 32768) >>> 16;
    if (z > longint'(HEADING_MAX)) z = longint'(HEADING_MAX);
    if (z < -longint'(HEADING_MAX)) z = -longint'(HEADING_MAX);
    return z[14:0];
  endfunction

  // Indexes above the last waypoint select the last one.
  function automatic int wp_slot(logic [1:0] idx);
    return (idx > 2'd2) ? 2 : int'(idx);
  endfunction

  function automatic bit captures(logic [1:0] idx, logic signed [15:0] x,
                                  logic signed [15:0] y);
    longint dx, dy, r;
    dx = longint'(x) - longint'(wp_x[wp_slot(idx)]);
    dy = longint'(y) - longint'(wp_y[wp_slot(idx)]);
    r  = longint'(capture_r);
    return (dx * dx + dy * dy) < (r * r);
  endfunction

  // Advances the predictor by one accepted tick; returns 1 when a result is due.
  function automatic bit predict_guidance(tick_t t, output guidance_t g);
    longint dx, dy;
    g = '0;
    if (!mission_active) return 1'b0;
    if (t.stop_request) begin
      mission_active = 1'b0;
      return 1'b0;
    end
    if (captures(route_index, t.pos_x, t.pos_y)) begin
      if (int'(route_index) >= WAYPOINT_COUNT - 1) begin
        g.mission_done = 1'b1;
        g.power_down   = 1'b1;
        mission_active = 1'b0;
      end else begin
        route_index = route_index + 2'd1;
      end
    end else begin
      dx = longint'(t.pos_x) - longint'(wp_x[wp_slot(route_index)]);
      dy = longint'(t.pos_y) - longint'(wp_y[wp_slot(route_index)]);
      g.heading_cmd    = bearing_to(-dx, -dy);
      g.heading_closed = 1'b1;
      g.thrust_cmd     = cruise_level;
    end
    g.waypoint_index = route_index;
    return 1'b1;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: register writes, accepted ticks and result transfers.
  always @(posedge clk) begin : monitor
    tick_t     tick;
    guidance_t want, got;
    if (rst) begin
      wp_x[0] = WP0_X_RST;
      wp_y[0] = WP0_Y_RST;
      wp_x[1] = WP1_X_RST;
      wp_y[1] = WP1_Y_RST;
      wp_x[2] = WP2_X_RST;
      wp_y[2] = WP2_Y_RST;
      capture_r      = RADIUS_RST;
      cruise_level   = THRUST_RST;
      route_index    = '0;
      mission_active = 1'b1;
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid && cfg_ready) begin
        case (wbg_reg_t'(cfg_index))
          REG_WP0_X:  wp_x[0] = cfg_data;
          REG_WP0_Y:  wp_y[0] = cfg_data;
          REG_WP1_X:  wp_x[1] = cfg_data;
          REG_WP1_Y:  wp_y[1] = cfg_data;
          REG_WP2_X:  wp_x[2] = cfg_data;
          REG_WP2_Y:  wp_y[2] = cfg_data;
          REG_RADIUS: capture_r = cfg_data[14:0];
          REG_THRUST: cruise_level = cfg_data[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        ticks_taken++;
        tick = s_axis_tdata;
        if (predict_guidance(tick, want)) expected_guidance.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_guidance.size() == 0) begin
          $error("guidance transfer with no result pending: %h", m_axis_tdata);
          mismatch_count++;
        end else begin
          want = expected_guidance.pop_front();
          check_field("heading_cmd", longint'(want.heading_cmd),
                      longint'(got.heading_cmd));
          check_field("heading_closed", want.heading_closed, got.heading_closed);
          check_field("thrust_cmd", want.thrust_cmd, got.thrust_cmd);
          check_field("mission_done", want.mission_done, got.mission_done);
          check_field("power_down", want.power_down, got.power_down);
          check_field("waypoint_index", want.waypoint_index, got.waypoint_index);
          check_field("fill", want.fill, got.fill);
        end
      end
    end
  end

  // Tick driver: keeps a tick up until its transfer, then idles at random.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || tick_taken) begin
      if (tick_backlog.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tick_backlog.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side ready, with random stalls.
  always @(negedge clk) begin
    if (sink_blocked) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Long receiver hold-off so that the block backs up into its input.
  initial begin
    forever begin
      @(receiver_hold);
      sink_blocked <= 1'b1;
      repeat (400) @(posedge clk);
      sink_blocked <= 1'b0;
    end
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] border_coord(longint c);
    case ($urandom_range(4))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return sat16(c);
      3:       return sat16(c + 1);
      default: return sat16(c - 1);
    endcase
  endfunction

  // Queues one tick and follows the route state it will cause.
  task automatic push_tick(logic signed [15:0] x, logic signed [15:0] y, logic stop);
    tick_t t;
    t = '0;
    t.pos_x = x;
    t.pos_y = y;
    t.stop_request = stop;
    if (plan_running) begin
      if (stop) begin
        plan_running = 1'b0;
      end else if (captures(plan_index, x, y)) begin
        if (plan_index >= 2'd2) plan_running = 1'b0;
        else plan_index = plan_index + 2'd1;
      end
    end
    tick_backlog.push_back(t);
    ticks_queued++;
  endtask

  // Tick at an offset from the current target waypoint.
  task automatic push_offset(longint dx, longint dy);
    push_tick(sat16(longint'(wp_x[wp_slot(plan_index)]) + dx),
              sat16(longint'(wp_y[wp_slot(plan_index)]) + dy), 1'b0);
  endtask

  // Random tick that stays outside the capture radius.
  task automatic push_steering_tick();
    logic signed [15:0] x, y;
    longint wx, wy, r;
    int     tries;
    wx = wp_x[wp_slot(plan_index)];
    wy = wp_y[wp_slot(plan_index)];
    r  = capture_r;
    tries = 0;
    do begin
      case ($urandom_range(9))
        5, 6, 7: begin
          x = sat16(wx + longint'($urandom_range(2 * r + 8)) - (r + 4));
          y = sat16(wy + longint'($urandom_range(2 * r + 8)) - (r + 4));
        end
        8: begin
          if ($urandom_range(1)) begin
            x = sat16(wx);
            y = $urandom;
          end else begin
            x = $urandom;
            y = sat16(wy);
          end
        end
        9: begin
          x = border_coord(wx);
          y = border_coord(wy);
        end
        default: begin
          x = $urandom;
          y = $urandom;
        end
      endcase
      tries++;
    end while (captures(plan_index, x, y) && tries < 32);
    // The far corner is always outside the largest radius.
    if (captures(plan_index, x, y)) begin
      x = (wx < 0) ? 16'sh7fff : 16'sh8000;
      y = (wy < 0) ? 16'sh7fff : 16'sh8000;
    end
    push_tick(x, y, 1'b0);
  endtask

  // Tick well inside the capture radius, offset toward the middle of the range.
  task automatic push_capture_tick();
    longint wx, wy, half, mx, my;
    wx = wp_x[wp_slot(plan_index)];
    wy = wp_y[wp_slot(plan_index)];
    half = (longint'(capture_r) - 1) / 2;
    if (half < 0) half = 0;
    mx = $urandom_range(half);
    my = $urandom_range(half);
    push_tick(sat16((wx >= 0) ? wx - mx : wx + mx),
              sat16((wy >= 0) ? wy - my : wy + my), 1'b0);
  endtask

  task automatic write_reg(wbg_reg_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every tick is taken and every result has come, then lets the
  // block finish any tick that gives no result.
  task automatic settle(int tail);
    while (ticks_taken != ticks_queued || expected_guidance.size() != 0)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin source_idle_pct = 82; sink_stall_pct = 0;  end
      2: begin source_idle_pct = 0;  sink_stall_pct = 82; end
      default: begin source_idle_pct = 8; sink_stall_pct = 8; end
    endcase
  endtask

  // Route, radius and thrust for one phase; some phases pin extremes.
  task automatic configure_phase(int phase);
    logic [15:0] v [8];
    int          i;
    for (i = 0; i < 6; i++) v[i] = $urandom;
    v[6] = $urandom_range(1, 300);
    if ($urandom_range(3) == 0) v[6] = $urandom_range(1, 32767);
    v[6][15] = $urandom_range(1);
    v[7] = $urandom;
    case (phase)
      0: begin
        v[6] = 16'h0000;
        v[7] = 16'h00ff;
      end
      1: begin
        v[0] = 16'h8000; v[1] = 16'h7fff;
        v[2] = 16'h7fff; v[3] = 16'h8000;
        v[4] = 16'h8000; v[5] = 16'h8000;
        v[6] = 16'h7fff;
        v[7] = 16'hff00;
      end
      5: v[6] = 16'hffff;
      9: begin
        v[4] = 16'h7fff;
        v[5] = 16'h7fff;
        v[7][7:0] = 8'hff;
      end
      default: ;
    endcase
    for (i = 0; i < 8; i++) write_reg(wbg_reg_t'(i), v[i]);
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    int phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_idle_mode(0);

    // Default route: field extremes, bearings on each axis and diagonal,
    // the half-turn clamp on both sides, and the capture boundary.
    push_tick(16'sh8000, 16'sh8000, 1'b0);
    push_tick(16'sh7fff, 16'sh7fff, 1'b0);
    push_tick(16'sh8000, 16'sh7fff, 1'b0);
    push_tick(16'sh7fff, 16'sh8000, 1'b0);
    push_offset(-500, 0);
    push_offset(500, 0);
    push_offset(500, 1);
    push_offset(0, -500);
    push_offset(0, 500);
    push_offset(-300, -300);
    push_offset(300, -300);
    push_offset(30, 0);
    push_offset(18, -24);
    settle(40);

    // Zero radius: sitting on the waypoint gives a zero bearing.
    write_reg(REG_RADIUS, 16'd0);
    push_offset(0, 0);
    push_offset(1, 0);
    settle(40);

    // Random phases; captures move the route on at phases 4 and 7.
    for (phase = 0; phase < 10; phase++) begin
      configure_phase(phase);
      set_idle_mode(phase % 4);
      if (phase == 2) -> receiver_hold;
      if (phase == 4 || phase == 7) push_capture_tick();
      repeat (132) push_steering_tick();
      settle(40);
    end

    // Complete the mission, then ticks to a stopped block, one with a stop.
    push_capture_tick();
    push_tick($urandom, $urandom, 1'b1);
    push_steering_tick();
    push_steering_tick();
    settle(64);

    if (mismatch_count == 0 && expected_guidance.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
